>>> sv/tga_pkg.sv
// Shared types and constants of the TGA run-length pixel decoder.
package tga_pkg;

   localparam int PIXEL_COUNT_BITS = 32;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] LITERAL_LIMIT = 8'h80;
   localparam logic [7:0] REPEAT_BIAS   = 8'd127;
   localparam logic [1:0] LAST_SLOT     = 2'd3;

   typedef enum logic [1:0] {
      CSR_RLE_MODE    = 2'd0,
      CSR_PIXEL_COUNT = 2'd1,
      CSR_SWAP        = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LITERAL = 2'd1,
      PH_REPEAT  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_image;
   } req_type;

   typedef struct packed {
      logic [7:0] chan0;
      logic [7:0] chan1;
      logic [7:0] chan2;
      logic [7:0] alpha;
      logic [7:0] run_length;
      logic       image_done;
      logic       overrun;
   } rsp_type;

   typedef struct packed {
      logic        rle_mode;
      logic        swap_red_blue;
      logic [31:0] pixel_count;
      logic        count_written;
   } cfg_type;

endpackage

>>> sv/tga_queue.sv
// Two-word queue between the byte intake and the pixel decoder.
module tga_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tga_pkg::req_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tga_pkg::req_type pop_data
);

   tga_pkg::req_type                       entry_ff [tga_pkg::QUEUE_DEPTH];
   logic [tga_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tga_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tga_pkg::QUEUE_CNT_BITS-1:0]     count_ff, count_in;
   logic                                   push, pop;

   localparam logic [tga_pkg::QUEUE_CNT_BITS-1:0] FULL_COUNT =
      tga_pkg::QUEUE_CNT_BITS'(tga_pkg::QUEUE_DEPTH);
   localparam logic [tga_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      tga_pkg::QUEUE_PTR_BITS'(tga_pkg::QUEUE_DEPTH - 1);

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/tga_decode.sv
// Pixel decoder: packet state, pixel assembly, run clipping and result register.
module tga_decode (
   input  logic             clock,
   input  logic             reset,
   input  tga_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  tga_pkg::req_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tga_pkg::rsp_type rsp_data
);

   localparam int PCB = tga_pkg::PIXEL_COUNT_BITS;

   tga_pkg::phase_type phase_ff, phase_in, s_phase;
   logic [7:0]     left_ff, left_in, s_left, left_dec;
   logic [1:0]     slot_ff, slot_in, s_slot;
   logic [23:0]    partial_ff, partial_in, s_partial;
   logic [PCB-1:0] done_cnt_ff, done_cnt_in, s_done_cnt;
   logic [PCB-1:0] remaining_ff, remaining_in, s_rem, rem_new;
   logic           exhausted_ff, exhausted_in, s_exh;
   logic           finished_ff, finished_in, s_finished;
   logic           clipped_ff, clipped_in, s_clipped;
   logic           recalc_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   tga_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [PCB-1:0] total;
   logic [PCB:0]   diff;
   logic [7:0]     byte_v, count, run_raw, run_fix;
   logic           take, start, active, is_header, is_literal_byte, clip, pix, done;
   logic           push;

   assign total  = cfg.pixel_count[PCB-1:0];
   assign byte_v = in_data.data_byte;
   assign start  = in_data.start_of_image;

   // hold intake while the remaining count is rebuilt after a count write
   assign in_ready = !recalc_ff && !cfg.count_written && (!rsp_valid_ff || rsp_ready);
   assign take     = in_valid & in_ready;

   // start of image clears the decoder before the byte is used
   assign s_phase    = start ? tga_pkg::PH_HEADER : phase_ff;
   assign s_left     = start ? 8'd0 : left_ff;
   assign s_slot     = start ? 2'd0 : slot_ff;
   assign s_partial  = start ? 24'd0 : partial_ff;
   assign s_done_cnt = start ? '0 : done_cnt_ff;
   assign s_rem      = start ? total : remaining_ff;
   assign s_exh      = start ? (total == '0) : exhausted_ff;
   assign s_finished = start ? 1'b0 : finished_ff;
   assign s_clipped  = start ? 1'b0 : clipped_ff;

   assign active    = !s_finished && !s_exh;
   assign is_header = cfg.rle_mode && (s_phase != tga_pkg::PH_LITERAL)
                      && (s_phase != tga_pkg::PH_REPEAT);
   assign is_literal_byte = (byte_v < tga_pkg::LITERAL_LIMIT);
   assign count     = is_literal_byte ? byte_v + 8'd1 : byte_v - tga_pkg::REPEAT_BIAS;
   assign clip      = {{(PCB-8){1'b0}}, count} > s_rem;
   assign pix       = !is_header && (s_slot == tga_pkg::LAST_SLOT);
   assign left_dec  = s_left - 8'd1;

   always_comb begin
      if (!cfg.rle_mode || s_phase == tga_pkg::PH_LITERAL) begin
         run_raw = 8'd1;
      end else begin
         run_raw = s_left;
      end
      if (run_raw == 8'd0) begin
         run_fix = 8'd1;
      end else if ({{(PCB-8){1'b0}}, run_raw} > s_rem) begin
         run_fix = s_rem[7:0];
      end else begin
         run_fix = run_raw;
      end
   end

   assign rem_new = s_rem - {{(PCB-8){1'b0}}, run_fix};
   assign done    = (rem_new == '0);
   assign push    = take && active && pix;
   assign diff    = {1'b0, total} - {1'b0, done_cnt_ff};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         phase_in = s_phase;
         if (active) begin
            if (is_header) begin
               phase_in = is_literal_byte ? tga_pkg::PH_LITERAL : tga_pkg::PH_REPEAT;
            end else if (pix) begin
               if (cfg.rle_mode) begin
                  unique case (s_phase)
                     tga_pkg::PH_LITERAL: begin
                        if (left_dec == 8'd0) begin
                           phase_in = tga_pkg::PH_HEADER;
                        end
                     end
                     default: begin
                        phase_in = tga_pkg::PH_HEADER;
                     end
                  endcase
               end
               if (done) begin
                  phase_in = tga_pkg::PH_HEADER;
               end
            end
         end
      end
   end

   // datapath and result
   always_comb begin
      left_in      = left_ff;
      slot_in      = slot_ff;
      partial_in   = partial_ff;
      done_cnt_in  = done_cnt_ff;
      remaining_in = remaining_ff;
      exhausted_in = exhausted_ff;
      finished_in  = finished_ff;
      clipped_in   = clipped_ff;
      rsp_data_in  = rsp_data_ff;
      if (recalc_ff) begin
         remaining_in = diff[PCB-1:0];
         exhausted_in = diff[PCB] || (diff == '0);
      end else if (take) begin
         left_in      = s_left;
         slot_in      = s_slot;
         partial_in   = s_partial;
         done_cnt_in  = s_done_cnt;
         remaining_in = s_rem;
         exhausted_in = s_exh;
         finished_in  = s_finished;
         clipped_in   = s_clipped;
         if (active) begin
            if (is_header) begin
               clipped_in = clip;
               left_in    = clip ? s_rem[7:0] : count;
               slot_in    = 2'd0;
            end else if (!pix) begin
               unique case (s_slot)
                  2'd0:    partial_in[7:0]   = byte_v;
                  2'd1:    partial_in[15:8]  = byte_v;
                  default: partial_in[23:16] = byte_v;
               endcase
               slot_in = s_slot + 2'd1;
            end else begin
               slot_in = 2'd0;
               rsp_data_in.overrun = 1'b0;
               if (cfg.rle_mode) begin
                  if (s_phase == tga_pkg::PH_LITERAL) begin
                     left_in = left_dec;
                     rsp_data_in.overrun = (left_dec == 8'd0) && s_clipped;
                  end else begin
                     left_in = 8'd0;
                     rsp_data_in.overrun = s_clipped;
                  end
               end
               done_cnt_in  = s_done_cnt + {{(PCB-8){1'b0}}, run_fix};
               remaining_in = rem_new;
               exhausted_in = done;
               if (done) begin
                  finished_in = 1'b1;
                  left_in     = 8'd0;
               end
               rsp_data_in.chan0      = cfg.swap_red_blue ? s_partial[23:16] : s_partial[7:0];
               rsp_data_in.chan1      = s_partial[15:8];
               rsp_data_in.chan2      = cfg.swap_red_blue ? s_partial[7:0] : s_partial[23:16];
               rsp_data_in.alpha      = byte_v;
               rsp_data_in.run_length = run_fix;
               rsp_data_in.image_done = done;
            end
         end
      end
   end

   assign rsp_valid_in = push || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tga_pkg::PH_HEADER;
         left_ff      <= 8'd0;
         slot_ff      <= 2'd0;
         partial_ff   <= 24'd0;
         done_cnt_ff  <= '0;
         remaining_ff <= PCB'(1);
         exhausted_ff <= 1'b0;
         finished_ff  <= 1'b0;
         clipped_ff   <= 1'b0;
         recalc_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         slot_ff      <= slot_in;
         partial_ff   <= partial_in;
         done_cnt_ff  <= done_cnt_in;
         remaining_ff <= remaining_in;
         exhausted_ff <= exhausted_in;
         finished_ff  <= finished_in;
         clipped_ff   <= clipped_in;
         recalc_ff    <= cfg.count_written;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_remaining_live: assert property (@(posedge clock) disable iff (reset)
      (!recalc_ff && !exhausted_ff) |-> (remaining_ff != '0))
      else $error("remaining count is zero on a live image");
   a_literal_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tga_pkg::PH_LITERAL) |-> (left_ff != 8'd0))
      else $error("literal packet open with no pixels left");
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      push |-> (run_fix != 8'd0))
      else $error("result with zero run length");
   a_done_finishes: assert property (@(posedge clock) disable iff (reset)
      (push && done) |=> finished_ff)
      else $error("image complete but decoder not finished");
`endif

endmodule

>>> sv/tga_rle_pixel_decoder.sv
// Top level of the TGA 32-bit pixel decoder: register file, byte queue, decoder.
//
//   port group   dir  handshake              payload
//   req_         in   req_valid/req_ready    tga_pkg::req_type (one byte)
//   rsp_         out  rsp_valid/rsp_ready    tga_pkg::rsp_type (one pixel or run)
//   csr_         in   csr_valid/csr_ready    csr_index, csr_data
//
// One byte per cycle while results are accepted and no count write holds intake;
// a result leaves the decoder register in the cycle after its alpha byte leaves
// the queue, which registers each byte first. A pixel-count write holds byte
// intake while the remaining count is rebuilt; csr_ready is always high.
// Synchronous reset clears all control state. A stalled result holds the decoder;
// up to two bytes then wait in the queue before req_ready drops.
module tga_rle_pixel_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tga_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tga_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);

   logic             rle_mode_ff, swap_ff;
   logic [31:0]      pixel_count_ff;
   logic             csr_write;
   tga_pkg::cfg_type cfg;
   logic             q_valid, q_ready;
   tga_pkg::req_type q_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_mode_ff    <= 1'b0;
         pixel_count_ff <= 32'd1;
         swap_ff        <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            tga_pkg::CSR_RLE_MODE:    rle_mode_ff    <= csr_data[0];
            tga_pkg::CSR_PIXEL_COUNT: pixel_count_ff <= csr_data;
            tga_pkg::CSR_SWAP:        swap_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg.rle_mode      = rle_mode_ff;
   assign cfg.swap_red_blue = swap_ff;
   assign cfg.pixel_count   = pixel_count_ff;
   assign cfg.count_written = csr_write && (csr_index == tga_pkg::CSR_PIXEL_COUNT);

   tga_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (req_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   tga_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/tga_rle_pixel_decoder_tb.sv
// Self-checking bench for the TGA pixel decoder: drives pixel-data bytes, checks each pixel word.
module tga_rle_pixel_decoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] MAX_COUNT    = 32'hFFFE_0001;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          CYCLE_LIMIT  = 300000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tga_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tga_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = tga_pkg::CSR_RLE_MODE;
   logic [31:0]      csr_data = '0;

   tga_rle_pixel_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // register copy and decoder state of the predictor
   logic               cfg_rle = 1'b0;
   logic [31:0]        cfg_count = 32'd1;
   logic               cfg_swap = 1'b0;
   tga_pkg::phase_type dec_phase = tga_pkg::PH_HEADER;
   logic [7:0]         dec_left = '0;
   logic [1:0]         dec_slot = '0;
   logic [23:0]        dec_pixel = '0;
   logic [31:0]        dec_count = '0;
   logic               dec_finished = 1'b0;
   logic               dec_clipped = 1'b0;

   tga_pkg::rsp_type   expected_pixels[$];
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   logic               start_pending = 1'b0;
   int unsigned        bytes_sent = 0;
   int unsigned        pixels_checked = 0;
   int unsigned        failures = 0;
   int unsigned        cycle_count = 0;

   function automatic void clear_decoder();
      dec_phase    = tga_pkg::PH_HEADER;
      dec_left     = '0;
      dec_slot     = '0;
      dec_pixel    = '0;
      dec_count    = '0;
      dec_finished = 1'b0;
      dec_clipped  = 1'b0;
   endfunction

   // Advance the decoder by one byte; return 1 when it completes a pixel word.
   function automatic bit decode_byte(input tga_pkg::req_type word,
                                      output tga_pkg::rsp_type pixel);
      logic [7:0]  value;
      logic [31:0] remaining;
      logic [31:0] count;
      logic [31:0] run;
      logic        over;
      value = word.data_byte;
      pixel = '0;
      if (word.start_of_image)
         clear_decoder();
      if (dec_finished || dec_count >= cfg_count)
         return 1'b0;
      remaining = cfg_count - dec_count;

      if (cfg_rle && dec_phase != tga_pkg::PH_LITERAL && dec_phase != tga_pkg::PH_REPEAT) begin
         count = (value < tga_pkg::LITERAL_LIMIT) ? 32'(value) + 32'd1
                                                  : 32'(value) - 32'(tga_pkg::REPEAT_BIAS);
         dec_clipped = (count > remaining);
         dec_left    = dec_clipped ? remaining[7:0] : count[7:0];
         dec_phase   = (value < tga_pkg::LITERAL_LIMIT) ? tga_pkg::PH_LITERAL
                                                        : tga_pkg::PH_REPEAT;
         dec_slot    = '0;
         return 1'b0;
      end

      if (dec_slot != tga_pkg::LAST_SLOT) begin
         dec_pixel[dec_slot*8 +: 8] = value;
         dec_slot = dec_slot + 2'd1;
         return 1'b0;
      end
      dec_slot = '0;

      if (!cfg_rle) begin
         run  = 32'd1;
         over = 1'b0;
      end else if (dec_phase == tga_pkg::PH_LITERAL) begin
         run      = 32'd1;
         dec_left = dec_left - 8'd1;
         over     = (dec_left == 8'd0) ? dec_clipped : 1'b0;
         if (dec_left == 8'd0)
            dec_phase = tga_pkg::PH_HEADER;
      end else begin
         run       = 32'(dec_left);
         over      = dec_clipped;
         dec_left  = '0;
         dec_phase = tga_pkg::PH_HEADER;
      end
      if (run == 32'd0)
         run = 32'd1;
      else if (run > remaining)
         run = remaining;

      dec_count = dec_count + run;
      pixel.image_done = (dec_count >= cfg_count);
      if (pixel.image_done) begin
         dec_finished = 1'b1;
         dec_phase    = tga_pkg::PH_HEADER;
         dec_left     = '0;
      end
      pixel.chan0      = cfg_swap ? dec_pixel[23:16] : dec_pixel[7:0];
      pixel.chan1      = dec_pixel[15:8];
      pixel.chan2      = cfg_swap ? dec_pixel[7:0] : dec_pixel[23:16];
      pixel.alpha      = value;
      pixel.run_length = run[7:0];
      pixel.overrun    = over;
      return 1'b1;
   endfunction

   function automatic string show(input tga_pkg::rsp_type pixel);
      return $sformatf("c0=%02h c1=%02h c2=%02h a=%02h run=%0d done=%b over=%b",
                       pixel.chan0, pixel.chan1, pixel.chan2, pixel.alpha,
                       pixel.run_length, pixel.image_done, pixel.overrun);
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   // result side: random stall, compare each accepted word with the oldest prediction
   always @(posedge clock) begin : check_pixels
      tga_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            note_failure($sformatf("unexpected word %s", show(rsp_data)));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.chan0 !== want.chan0 || rsp_data.chan1 !== want.chan1 ||
                rsp_data.chan2 !== want.chan2 || rsp_data.alpha !== want.alpha ||
                rsp_data.run_length !== want.run_length ||
                rsp_data.image_done !== want.image_done ||
                rsp_data.overrun !== want.overrun)
               note_failure($sformatf("word %0d expected %s, got %s", pixels_checked,
                                      show(want), show(rsp_data)));
            pixels_checked++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      tga_pkg::req_type word;
      tga_pkg::rsp_type pixel;
      word.data_byte      = value;
      word.start_of_image = start_pending;
      start_pending       = 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      if (decode_byte(word, pixel))
         expected_pixels.push_back(pixel);
      bytes_sent++;
   endtask

   task automatic send_pixel();
      repeat (4) send_byte(8'($urandom_range(255)));
   endtask

   // Drop valid, let every predicted word drain, then give the queue time to empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input tga_pkg::csr_index_type index,
                            input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         tga_pkg::CSR_RLE_MODE:    cfg_rle   = value[0];
         tga_pkg::CSR_PIXEL_COUNT: cfg_count = value;
         tga_pkg::CSR_SWAP:        cfg_swap  = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic rle, input logic [31:0] count, input logic swap);
      write_reg(tga_pkg::CSR_RLE_MODE, {31'd0, rle});
      write_reg(tga_pkg::CSR_PIXEL_COUNT, count);
      write_reg(tga_pkg::CSR_SWAP, {31'd0, swap});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_count();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60)
         return $urandom_range(1, 12);
      else if (pick < 80)
         return $urandom_range(13, 400);
      else if (pick < 90)
         return MAX_COUNT;
      else if (pick < 95)
         return 32'd1;
      return $urandom_range(1, MAX_COUNT);
   endfunction

   // Well-formed image with random content, a little noise and the odd restart.
   task automatic send_image(input int unsigned budget);
      int unsigned stop;
      int unsigned n;
      logic [31:0] left;
      stop = bytes_sent + budget;
      left = cfg_count;
      start_pending = 1'b1;
      while (left != 0 && bytes_sent < stop) begin
         if ($urandom_range(99) < 4) begin
            send_byte(8'($urandom_range(255)));
         end else if ($urandom_range(99) < 3) begin
            start_pending = 1'b1;
            left = cfg_count;
         end else if (!cfg_rle) begin
            send_pixel();
            left--;
         end else if ($urandom_range(1)) begin
            n = $urandom_range(1, 4);
            send_byte(8'(n - 1));
            // clipped literal: skip the pixels past the count
            if (n > left)
               n = left;
            repeat (n) send_pixel();
            left = left - n;
         end else begin
            n = $urandom_range(1, 128);
            send_byte(8'(n + 127));
            send_pixel();
            left = (n > left) ? 32'd0 : left - n;
         end
      end
      repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
   endtask

   task automatic test_raw_mode();
      wait_idle();
      set_config(1'b0, 32'd2, 1'b0);
      start_pending = 1'b1;
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h55); send_byte(8'hAA);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'hAA); send_byte(8'h55);
      send_byte(8'h3C);
   endtask

   task automatic test_run_length_packets();
      wait_idle();
      // longest repeat, clipped to a count of three
      set_config(1'b1, 32'd3, 1'b1);
      start_pending = 1'b1;
      send_byte(8'hFF);
      send_pixel();
      wait_idle();
      // longest literal, clipped after one pixel; the trailing byte is dropped
      set_config(1'b1, 32'd1, 1'b0);
      start_pending = 1'b1;
      send_byte(8'h7F);
      send_pixel();
      send_byte(8'hC3);
      wait_idle();
      // shortest repeat and shortest literal
      set_config(1'b1, 32'd2, 1'b1);
      start_pending = 1'b1;
      send_byte(8'h80);
      send_pixel();
      send_byte(8'h00);
      send_pixel();
   endtask

   task automatic test_count_change();
      wait_idle();
      set_config(1'b0, 32'd10, 1'b0);
      start_pending = 1'b1;
      repeat (2) send_pixel();
      // count now below the pixels already out: bytes are dropped
      wait_idle();
      set_config(1'b0, 32'd1, 1'b0);
      send_pixel();
      wait_idle();
      set_config(1'b0, MAX_COUNT, 1'b1);
      send_pixel();
   endtask

   task automatic test_mode_switch();
      wait_idle();
      set_config(1'b1, 32'd40, 1'b0);
      start_pending = 1'b1;
      send_byte(8'h83);
      send_byte(8'h12); send_byte(8'h34);
      // finish the half-built pixel in raw mode, then resume the repeat packet
      wait_idle();
      set_config(1'b0, 32'd40, 1'b0);
      send_byte(8'h56); send_byte(8'h78);
      wait_idle();
      set_config(1'b1, 32'd40, 1'b1);
      send_pixel();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int unsigned budget);
      int unsigned stop;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop = bytes_sent + budget;
      while (bytes_sent < stop) begin
         wait_idle();
         set_config(1'($urandom_range(1)), pick_count(), 1'($urandom_range(1)));
         send_image(stop - bytes_sent);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_raw_mode();
      test_run_length_packets();
      test_count_change();
      test_mode_switch();
      test_random_traffic(0, 0, 120);
      test_random_traffic(51, 0, 120);
      test_random_traffic(0, 51, 120);
      test_random_traffic(7, 7, 120);
      wait_idle();
      $display("Fed %0d bytes of raw and run-length images (clipped packets, count and mode",
               bytes_sent);
      $display("changes, four flow-control mixes); %0d pixel words compared, %0d bad.",
               pixels_checked, failures);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
sv/tga_pkg.sv
sv/tga_queue.sv
sv/tga_decode.sv
sv/tga_rle_pixel_decoder.sv
bench/tga_rle_pixel_decoder_tb.sv
